>>> src/cbq_pkg.sv
`timescale 1ns / 1ps

package cbq_pkg;

  localparam int COEF_W    = 27;
  localparam int COEF_FRAC = 24;
  localparam int CH_W      = 3;
  localparam int NCH_W     = 4;
  localparam int CFG_IDX_W = 3;
  localparam int TAP_W     = 3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DRAIN,
    ST_RND,
    ST_FIN
  } cbq_state_t;

  // configuration register indices
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_IN0,
    REG_COEF_IN1,
    REG_COEF_IN2,
    REG_COEF_FB1,
    REG_COEF_FB2,
    REG_NUM_CH
  } cbq_reg_t;

  // one product per tap of a stage
  typedef enum logic [TAP_W-1:0] {
    TAP_X0,
    TAP_X1,
    TAP_X2,
    TAP_Y1,
    TAP_Y2
  } cbq_tap_t;

  typedef struct packed {
    logic     load;
    logic     mul;
    cbq_tap_t tap;
    logic     stage;
    logic     acc_first;
    logic     acc_add;
    logic     rnd;
    logic     finish;
  } cbq_cmd_t;

  typedef struct packed {
    logic in_range;
  } cbq_sts_t;

endpackage

>>> src/cbq_ctrl.sv
`timescale 1ns / 1ps

module cbq_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  output logic             out_tvalid,
  input  logic             out_tready,
  input  cbq_pkg::cbq_sts_t sts,
  output cbq_pkg::cbq_cmd_t cmd
);

  localparam int TAP_W = cbq_pkg::TAP_W;

  cbq_pkg::cbq_state_t state_r, state_nxt;
  logic [cbq_pkg::TAP_W-1:0] step_r, step_nxt;
  logic stage_r, stage_nxt;
  logic out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cbq_pkg::ST_IDLE;
      step_r      <= '0;
      stage_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      stage_r     <= stage_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    stage_nxt     = stage_r;
    in_tready     = 1'b0;
    cmd           = '0;
    cmd.tap       = cbq_pkg::cbq_tap_t'(step_r);
    cmd.stage     = stage_r;
    unique case (state_r)
      cbq_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          step_nxt  = '0;
          stage_nxt = 1'b0;
          state_nxt = sts.in_range ? cbq_pkg::ST_MUL : cbq_pkg::ST_FIN;
        end
      end
      cbq_pkg::ST_MUL: begin
        cmd.mul       = 1'b1;
        cmd.acc_add   = (step_r != TAP_W'(cbq_pkg::TAP_X0));
        cmd.acc_first = (step_r == TAP_W'(cbq_pkg::TAP_X1));
        if (step_r == TAP_W'(cbq_pkg::TAP_Y2)) begin
          state_nxt = cbq_pkg::ST_DRAIN;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      cbq_pkg::ST_DRAIN: begin
        cmd.acc_add = 1'b1;
        state_nxt   = cbq_pkg::ST_RND;
      end
      cbq_pkg::ST_RND: begin
        cmd.rnd = 1'b1;
        if (!stage_r) begin
          stage_nxt = 1'b1;
          step_nxt  = '0;
          state_nxt = cbq_pkg::ST_MUL;
        end else begin
          state_nxt = cbq_pkg::ST_FIN;
        end
      end
      cbq_pkg::ST_FIN: begin
        if (!out_valid_r || out_tready) begin
          cmd.finish = 1'b1;
          state_nxt  = cbq_pkg::ST_IDLE;
        end
      end
      default: state_nxt = cbq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

>>> src/cbq_datapath.sv
`timescale 1ns / 1ps

module cbq_datapath #(
  parameter int MAX_CHANNELS = 8,
  parameter int SAMPLE_BITS  = 24
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  cbq_pkg::cbq_cmd_t                 cmd,
  output cbq_pkg::cbq_sts_t                 sts,
  input  logic [cbq_pkg::CH_W-1:0]          in_channel,
  input  logic [SAMPLE_BITS-1:0]            in_sample,
  input  logic                              cfg_valid,
  input  logic [cbq_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cbq_pkg::COEF_W-1:0]        cfg_data,
  output logic [cbq_pkg::CH_W-1:0]          out_channel,
  output logic [SAMPLE_BITS-1:0]            out_sample
);

  localparam int COEF_W = cbq_pkg::COEF_W;
  localparam int CH_W   = cbq_pkg::CH_W;
  localparam int NCH_W  = cbq_pkg::NCH_W;
  localparam int CH_AW  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int PROD_W = SAMPLE_BITS + COEF_W;
  localparam int ACC_W  = PROD_W + 3;
  localparam int Q_W    = ACC_W - cbq_pkg::COEF_FRAC;
  localparam logic signed [ACC_W-1:0] RND_BIAS = ACC_W'(64'd1 << (cbq_pkg::COEF_FRAC - 1));
  localparam logic signed [Q_W-1:0] Q_HI = Q_W'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
  localparam logic signed [Q_W-1:0] Q_LO = -Q_HI - Q_W'(1);
  // history row: stage one x1 x2 y1 y2, then stage two x1 x2 y1 y2
  localparam int H_X1 = 0;
  localparam int H_X2 = 1;
  localparam int H_Y1 = 2;
  localparam int H_Y2 = 3;
  localparam int H_STAGE = 4;

  typedef logic [2*H_STAGE-1:0][SAMPLE_BITS-1:0] hist_row_t;

  logic signed [COEF_W-1:0] coef_in0_r, coef_in1_r, coef_in2_r, coef_fb1_r, coef_fb2_r;
  logic [NCH_W-1:0] num_ch_r;
  logic [NCH_W-1:0] num_ch_nxt;
  logic num_ch_wr;

  hist_row_t hist_mem [MAX_CHANNELS];
  logic [MAX_CHANNELS-1:0] row_valid_r;
  hist_row_t row_r;
  logic row_ok_r;

  logic [CH_W-1:0] ch_r;
  logic [SAMPLE_BITS-1:0] sample_r;
  logic range_r;
  logic [CH_AW-1:0] idx_in, idx_r;
  logic [CH_AW+CH_W-1:0] ch_ext;

  logic signed [SAMPLE_BITS-1:0] ya_r, yb_r;
  logic signed [SAMPLE_BITS-1:0] hx1, hx2, hy1, hy2, mul_a;
  logic signed [COEF_W-1:0] mul_b;
  logic signed [PROD_W-1:0] prod_w, prod_r;
  logic signed [ACC_W-1:0] acc_r, rsum;
  logic signed [Q_W-1:0] q_w;
  logic signed [SAMPLE_BITS-1:0] y_sat;
  hist_row_t row_eff, row_new;

  logic [CH_W-1:0] out_ch_r;
  logic [SAMPLE_BITS-1:0] out_sample_r;

  assign num_ch_wr = cfg_valid && (cfg_index == cbq_pkg::REG_NUM_CH);

  always_comb begin
    num_ch_nxt = cfg_data[NCH_W-1:0];
    if (num_ch_nxt == '0) begin
      num_ch_nxt = NCH_W'(1);
    end else if (32'(num_ch_nxt) > MAX_CHANNELS) begin
      num_ch_nxt = NCH_W'(MAX_CHANNELS);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_in0_r <= '0;
      coef_in1_r <= '0;
      coef_in2_r <= '0;
      coef_fb1_r <= '0;
      coef_fb2_r <= '0;
      num_ch_r   <= NCH_W'(1);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        cbq_pkg::REG_COEF_IN0: coef_in0_r <= cfg_data;
        cbq_pkg::REG_COEF_IN1: coef_in1_r <= cfg_data;
        cbq_pkg::REG_COEF_IN2: coef_in2_r <= cfg_data;
        cbq_pkg::REG_COEF_FB1: coef_fb1_r <= cfg_data;
        cbq_pkg::REG_COEF_FB2: coef_fb2_r <= cfg_data;
        cbq_pkg::REG_NUM_CH:   num_ch_r   <= num_ch_nxt;
        default: ;
      endcase
    end
  end

  assign ch_ext       = (CH_AW+CH_W)'(in_channel);
  assign idx_in       = ch_ext[CH_AW-1:0];
  assign sts.in_range = (NCH_W'(in_channel) < num_ch_r);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ch_r     <= in_channel;
      sample_r <= in_sample;
      range_r  <= sts.in_range;
      idx_r    <= idx_in;
      if (sts.in_range) begin
        row_r <= hist_mem[idx_in];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_ok_r    <= 1'b0;
      row_valid_r <= '0;
    end else begin
      if (cmd.load) begin
        row_ok_r <= sts.in_range && row_valid_r[idx_in];
      end
      if (num_ch_wr) begin
        row_valid_r <= '0;
      end else if (cmd.finish && range_r) begin
        row_valid_r[idx_r] <= 1'b1;
      end
    end
  end

  assign row_eff = row_ok_r ? row_r : '0;

  always_comb begin
    if (cmd.stage) begin
      hx1 = row_eff[H_STAGE + H_X1];
      hx2 = row_eff[H_STAGE + H_X2];
      hy1 = row_eff[H_STAGE + H_Y1];
      hy2 = row_eff[H_STAGE + H_Y2];
    end else begin
      hx1 = row_eff[H_X1];
      hx2 = row_eff[H_X2];
      hy1 = row_eff[H_Y1];
      hy2 = row_eff[H_Y2];
    end
  end

  always_comb begin
    case (cmd.tap)
      cbq_pkg::TAP_X0: begin
        mul_a = cmd.stage ? ya_r : sample_r;
        mul_b = coef_in0_r;
      end
      cbq_pkg::TAP_X1: begin
        mul_a = hx1;
        mul_b = coef_in1_r;
      end
      cbq_pkg::TAP_X2: begin
        mul_a = hx2;
        mul_b = coef_in2_r;
      end
      cbq_pkg::TAP_Y1: begin
        mul_a = hy1;
        mul_b = coef_fb1_r;
      end
      cbq_pkg::TAP_Y2: begin
        mul_a = hy2;
        mul_b = coef_fb2_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_w = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_r <= prod_w;
    end
    if (cmd.acc_add) begin
      acc_r <= cmd.acc_first ? ACC_W'(prod_r) : acc_r + ACC_W'(prod_r);
    end
  end

  // round half up, then saturate
  assign rsum = acc_r + RND_BIAS;
  assign q_w  = Q_W'(rsum >>> cbq_pkg::COEF_FRAC);

  always_comb begin
    if (q_w > Q_HI) begin
      y_sat = Q_HI[SAMPLE_BITS-1:0];
    end else if (q_w < Q_LO) begin
      y_sat = Q_LO[SAMPLE_BITS-1:0];
    end else begin
      y_sat = q_w[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rnd) begin
      if (cmd.stage) begin
        yb_r <= y_sat;
      end else begin
        ya_r <= y_sat;
      end
    end
  end

  always_comb begin
    row_new                    = row_eff;
    row_new[H_X1]              = sample_r;
    row_new[H_X2]              = row_eff[H_X1];
    row_new[H_Y1]              = ya_r;
    row_new[H_Y2]              = row_eff[H_Y1];
    row_new[H_STAGE + H_X1]    = ya_r;
    row_new[H_STAGE + H_X2]    = row_eff[H_STAGE + H_X1];
    row_new[H_STAGE + H_Y1]    = yb_r;
    row_new[H_STAGE + H_Y2]    = row_eff[H_STAGE + H_Y1];
  end

  always_ff @(posedge clk) begin
    if (cmd.finish && range_r) begin
      hist_mem[idx_r] <= row_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_ch_r     <= ch_r;
      out_sample_r <= range_r ? yb_r : '0;
    end
  end

  assign out_channel = out_ch_r;
  assign out_sample  = out_sample_r;

endmodule

>>> src/cascaded_biquad_filter_unit.sv
`timescale 1ns / 1ps
// channel | dir | handshake             | payload
// in_     | in  | in_tvalid/in_tready   | tuser: channel[2:0]; tdata: sample
// out_    | out | out_tvalid/out_tready | tuser: channel[2:0]; tdata: filtered sample
// cfg_    | in  | cfg_valid/cfg_ready   | cfg_index, cfg_data
//
// An in-range sample uses one shared multiplier, five products per stage and two stages,
// plus drain, rounding and write-back; an unused channel goes from load straight to the finish step.
// Synchronous active-low reset; history is zero after reset and after a
// channel-count write. A waiting result holds in the output register while the
// next sample is taken; a stalled output only holds the write-back step.

module cascaded_biquad_filter_unit #(
  parameter int MAX_CHANNELS = 8,
  parameter int SAMPLE_BITS  = 24
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [cbq_pkg::CH_W-1:0]              in_tuser,  // [2:0] channel
  input  logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] in_tdata,  // sample, zero padded
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [cbq_pkg::CH_W-1:0]              out_tuser, // [2:0] channel
  output logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] out_tdata, // filtered sample, zero padded
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [cbq_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [cbq_pkg::COEF_W-1:0]            cfg_data
);

  localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;

  cbq_pkg::cbq_cmd_t cmd;
  cbq_pkg::cbq_sts_t sts;
  logic [SAMPLE_BITS-1:0] out_sample;

  assign cfg_ready = 1'b1;

  cbq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  cbq_datapath #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_channel  (in_tuser),
    .in_sample   (in_tdata[SAMPLE_BITS-1:0]),
    .cfg_valid   (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .out_channel (out_tuser),
    .out_sample  (out_sample)
  );

  assign out_tdata = TDATA_W'(out_sample);

endmodule

>>> src/cbq_checker.sv
`timescale 1ns / 1ps

module cbq_checker #(
  parameter int TDATA_W = 24
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tvalid,
  input logic                          in_tready,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [cbq_pkg::CH_W-1:0]      out_tuser,
  input logic [TDATA_W-1:0]            out_tdata,
  input logic                          cfg_ready
);

  // stalled result must hold
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("output changed while stalled");

  // one sample in flight: no back-to-back input transactions
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while a sample is in progress");

  // a new result appears only while the input side is busy
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result without a sample in progress");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready)
    else $error("configuration port not ready");

endmodule

bind cascaded_biquad_filter_unit cbq_checker #(
  .TDATA_W (TDATA_W)
) u_cbq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tuser  (out_tuser),
  .out_tdata  (out_tdata),
  .cfg_ready  (cfg_ready)
);
